### hdl/msp_pkg.sv
// Shared constants, types and the motif classifier for the motif sync pair block.
package msp_pkg;

  // Sizing
  localparam int WINDOW_MAX  = 64;
  localparam int LAG_MAX     = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int DEPTH       = WINDOW_MAX + LAG_MAX + 2;

  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int K_W    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int LAG_W  = (LAG_MAX > 0) ? $clog2(LAG_MAX + 1) : 1;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);

  // Fixed field widths of the ports
  localparam int WLEN_W = 7;
  localparam int LREG_W = 5;
  localparam int THR_W  = 7;
  localparam int CIDX_W = 2;
  localparam int CDAT_W = 7;
  localparam int DIR_W  = 2;
  localparam int WGT_W  = 5;
  localparam int SYNC_W = 7;
  localparam int LAGO_W = 5;
  localparam int MOT_W  = 3;

  // Register indexes
  localparam logic [CIDX_W-1:0] CFG_WINDOW_LEN = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_LAG_MIN    = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_LAG_MAX    = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_THRESHOLD  = 2'd3;

  // Register reset values
  localparam logic [WLEN_W-1:0] WINDOW_LEN_RST = 7'd64;
  localparam logic [LREG_W-1:0] LAG_MIN_RST    = 5'd0;
  localparam logic [LREG_W-1:0] LAG_MAX_RST    = 5'd16;
  localparam logic [THR_W-1:0]  THRESHOLD_RST  = 7'd32;

  // Motif codes
  localparam logic [MOT_W-1:0] MOT_ZERO   = 3'd0;
  localparam logic [MOT_W-1:0] MOT_FALL   = 3'd1;
  localparam logic [MOT_W-1:0] MOT_VALLEY = 3'd2;
  localparam logic [MOT_W-1:0] MOT_PEAK   = 3'd3;
  localparam logic [MOT_W-1:0] MOT_RISE   = 3'd4;
  localparam logic [MOT_W-1:0] MOT_OTHER  = 3'd5;

  // Direction codes
  localparam logic [DIR_W-1:0] DIR_NONE   = 2'd0;
  localparam logic [DIR_W-1:0] DIR_UNDIR  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_X_LEAD = 2'd2;
  localparam logic [DIR_W-1:0] DIR_Y_LEAD = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic             load;         // store one sample pair
    logic             last_load;    // the stored pair closes the window
    logic             score_start;  // clear counters and bests
    logic             issue;        // read one window position
    logic [K_W-1:0]   k;            // window position
    logic [LAG_W-1:0] l;            // lag under test
    logic             lag_end;      // last position of this lag
    logic             result_load;  // capture the decision
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [CNT_W-1:0] w_eff;
    logic [LAG_W-1:0] lag_min;
    logic [LAG_W-1:0] lmax_eff;
    logic             skip;         // no lag or no position to score
  } dp_stat_t;

  // Classify a run of three samples
  function automatic logic [MOT_W-1:0] motif_code(
    input logic signed [SAMPLE_BITS-1:0] a,
    input logic signed [SAMPLE_BITS-1:0] b,
    input logic signed [SAMPLE_BITS-1:0] c
  );
    logic [MOT_W-1:0] code;
    if (a > b && b > c)      code = MOT_FALL;
    else if (a > b && b < c) code = MOT_VALLEY;
    else if (a < b && b > c) code = MOT_PEAK;
    else if (a < b && b < c) code = MOT_RISE;
    else if (a == '0 && b == '0 && c == '0) code = MOT_ZERO;
    else code = MOT_OTHER;
    return code;
  endfunction

endpackage

### hdl/motif_sync_pair.sv
// Top level of the motif synchronization block for one channel pair.
//
// Sample pairs stream in one per cycle while the input is open; each, while the
// store has room, is stored with its nonzero flags and the motif of the run it
// closes. The pair marked last starts scoring: the block walks every lag from
// lag_min to min(lag_max, 16) and, for each, every window position, one position
// per cycle through the two read ports of the motif store. A last pair thus keeps
// the input closed through the score walk, a drain step and the result load; the
// score walk is skipped when no lag or position is scored. The result sits in an
// output register, and samples of the next window are taken while it waits; a
// last pair whose scoring ends while an earlier result still waits holds the
// input closed until that result is taken. Configuration writes are taken at any
// time, one per cycle, and must only come while the block is idle.
module motif_sync_pair (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [msp_pkg::CIDX_W-1:0]             cfg_index_i,
  input  logic [msp_pkg::CDAT_W-1:0]             cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [msp_pkg::SAMPLE_BITS-1:0] sample_x_i,
  input  logic signed [msp_pkg::SAMPLE_BITS-1:0] sample_y_i,
  input  logic                                   last_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic                                   edge_res_o,
  output logic [msp_pkg::DIR_W-1:0]              direction_o,
  output logic [msp_pkg::WGT_W-1:0]              weight_o,
  output logic [msp_pkg::SYNC_W-1:0]             sync_xy_o,
  output logic [msp_pkg::SYNC_W-1:0]             sync_yx_o,
  output logic [msp_pkg::LAGO_W-1:0]             lag_xy_o,
  output logic [msp_pkg::LAGO_W-1:0]             lag_yx_o
);
  import msp_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Registers accept every transfer
  assign cfg_ready_o = 1'b1;

  msp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_i      (last_i),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  msp_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .sample_x_i  (sample_x_i),
    .sample_y_i  (sample_y_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .edge_res_o  (edge_res_o),
    .direction_o (direction_o),
    .weight_o    (weight_o),
    .sync_xy_o   (sync_xy_o),
    .sync_yx_o   (sync_yx_o),
    .lag_xy_o    (lag_xy_o),
    .lag_yx_o    (lag_yx_o)
  );

endmodule

### hdl/msp_ctrl.sv
// Controller: load, score walk over lags and positions, result hand-off.
module msp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                last_i,
  input  logic                out_ready_i,
  input  msp_pkg::dp_stat_t   stat_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  output msp_pkg::ctrl_cmd_t  cmd_o
);
  import msp_pkg::*;

  typedef enum logic [3:0] {
    ST_LOAD   = 4'b0001,
    ST_SCORE  = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [K_W-1:0]   k_q, k_d;
  logic [LAG_W-1:0] l_q, l_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;
  logic             k_end;
  logic             out_free;

  assign accept   = in_valid_i && (state_q == ST_LOAD);
  assign k_end    = (CNT_W'(k_q) + CNT_W'(1)) == stat_i.w_eff;
  assign out_free = !out_valid_q || out_ready_i;

  // Sequence the window
  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    l_d         = l_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.k     = k_q;
    cmd_o.l     = l_q;

    // drop the result once it is taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_LOAD: begin
        cmd_o.load      = accept;
        cmd_o.last_load = accept && last_i;
        if (accept && last_i) begin
          cmd_o.score_start = 1'b1;
          k_d = '0;
          l_d = stat_i.lag_min;
          state_d = stat_i.skip ? ST_FINISH : ST_SCORE;
        end
      end
      ST_SCORE: begin
        cmd_o.issue   = 1'b1;
        cmd_o.lag_end = k_end;
        if (k_end) begin
          k_d = '0;
          if (l_q == stat_i.lmax_eff) begin
            state_d = ST_DRAIN;
          end else begin
            l_d = l_q + LAG_W'(1);
          end
        end else begin
          k_d = k_q + K_W'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.result_load = 1'b1;
          out_valid_d = 1'b1;
          state_d = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // Hold state and loop counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      k_q         <= '0;
      l_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      l_q         <= l_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_LOAD);
  assign out_valid_o = out_valid_q;

endmodule

### hdl/msp_datapath.sv
// Datapath: registers, motif store, match counting, best tracking and decision.
module msp_datapath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [msp_pkg::CIDX_W-1:0]             cfg_index_i,
  input  logic [msp_pkg::CDAT_W-1:0]             cfg_data_i,
  input  logic signed [msp_pkg::SAMPLE_BITS-1:0] sample_x_i,
  input  logic signed [msp_pkg::SAMPLE_BITS-1:0] sample_y_i,
  input  msp_pkg::ctrl_cmd_t                     cmd_i,
  output msp_pkg::dp_stat_t                      stat_o,
  output logic                                   edge_res_o,
  output logic [msp_pkg::DIR_W-1:0]              direction_o,
  output logic [msp_pkg::WGT_W-1:0]              weight_o,
  output logic [msp_pkg::SYNC_W-1:0]             sync_xy_o,
  output logic [msp_pkg::SYNC_W-1:0]             sync_yx_o,
  output logic [msp_pkg::LAGO_W-1:0]             lag_xy_o,
  output logic [msp_pkg::LAGO_W-1:0]             lag_yx_o
);
  import msp_pkg::*;

  // Configuration registers
  logic [WLEN_W-1:0] window_len_q;
  logic [LREG_W-1:0] lag_min_q;
  logic [LREG_W-1:0] lag_max_q;
  logic [THR_W-1:0]  threshold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q <= WINDOW_LEN_RST;
      lag_min_q    <= LAG_MIN_RST;
      lag_max_q    <= LAG_MAX_RST;
      threshold_q  <= THRESHOLD_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_WINDOW_LEN: window_len_q <= cfg_data_i[WLEN_W-1:0];
        CFG_LAG_MIN:    lag_min_q    <= cfg_data_i[LREG_W-1:0];
        CFG_LAG_MAX:    lag_max_q    <= cfg_data_i[LREG_W-1:0];
        CFG_THRESHOLD:  threshold_q  <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the window and lag range
  logic [CNT_W-1:0] w_eff;
  logic [LAG_W-1:0] lmax_eff;

  assign w_eff    = (32'(window_len_q) > WINDOW_MAX) ? CNT_W'(WINDOW_MAX)
                                                     : CNT_W'(window_len_q);
  assign lmax_eff = (32'(lag_max_q) > LAG_MAX) ? LAG_W'(LAG_MAX) : LAG_W'(lag_max_q);

  assign stat_o.w_eff    = w_eff;
  assign stat_o.lmax_eff = lmax_eff;
  assign stat_o.lag_min  = LAG_W'(lag_min_q);
  assign stat_o.skip     = (w_eff == '0) || (32'(lag_min_q) > 32'(lmax_eff));

  // Sample history and fill count
  logic signed [SAMPLE_BITS-1:0] hx0_q, hx1_q, hy0_q, hy1_q;
  logic [FILL_W-1:0]             fill_q;
  logic                          room;
  logic [MOT_W-1:0]              mot_x_new, mot_y_new;

  assign room      = 32'(fill_q) < DEPTH;
  assign mot_x_new = motif_code(hx1_q, hx0_q, sample_x_i);
  assign mot_y_new = motif_code(hy1_q, hy0_q, sample_y_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hx0_q  <= '0;
      hx1_q  <= '0;
      hy0_q  <= '0;
      hy1_q  <= '0;
      fill_q <= '0;
    end else begin
      if (cmd_i.load) begin
        if (cmd_i.last_load) begin
          hx0_q <= '0;
          hx1_q <= '0;
          hy0_q <= '0;
          hy1_q <= '0;
        end else begin
          hx0_q <= sample_x_i;
          hx1_q <= hx0_q;
          hy0_q <= sample_y_i;
          hy1_q <= hy0_q;
        end
        if (room) begin
          fill_q <= fill_q + FILL_W'(1);
        end
      end else if (cmd_i.result_load) begin
        fill_q <= '0;
      end
    end
  end

  // Motif and nonzero stores: one write, registered reads
  logic [2*MOT_W-1:0] mot_mem [DEPTH];
  logic [1:0]         nz_mem  [DEPTH];
  logic [2*MOT_W-1:0] mot_k_q, mot_p_q;
  logic [1:0]         nz_p_q;
  logic [ADDR_W-1:0]  addr_k, addr_p;

  assign addr_k = ADDR_W'(cmd_i.k);
  assign addr_p = ADDR_W'(cmd_i.k) + ADDR_W'(cmd_i.l);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && room) begin
      nz_mem[fill_q[ADDR_W-1:0]] <= {sample_x_i != '0, sample_y_i != '0};
      if (fill_q >= FILL_W'(2)) begin
        mot_mem[ADDR_W'(fill_q - FILL_W'(2))] <= {mot_x_new, mot_y_new};
      end
    end
    mot_k_q <= mot_mem[addr_k];
    mot_p_q <= mot_mem[addr_p];
    nz_p_q  <= nz_mem[addr_p];
  end

  // Read-stage side information
  logic             s1_vld_q, s1_lag_end_q;
  logic             s1_okk_q, s1_okp_q, s1_nzok_q;
  logic [LAG_W-1:0] s1_l_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q     <= 1'b0;
      s1_lag_end_q <= 1'b0;
    end else begin
      s1_vld_q     <= cmd_i.issue;
      s1_lag_end_q <= cmd_i.lag_end;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_okk_q  <= (FILL_W'(addr_k) + FILL_W'(2)) < fill_q;
    s1_okp_q  <= (FILL_W'(addr_p) + FILL_W'(2)) < fill_q;
    s1_nzok_q <= FILL_W'(addr_p) < fill_q;
    s1_l_q    <= cmd_i.l;
  end

  // Count matches and keep the first maximum per direction
  logic [MOT_W-1:0] mxk, myk, mxp, myp;
  logic             eq_xy, eq_yx, flat_n;
  logic [CNT_W-1:0] cnt_xy_q, cnt_yx_q, cxy_n, cyx_n, fin_xy, fin_yx;
  logic             flat_q;
  logic [CNT_W-1:0] best_xy_q, best_yx_q;
  logic [LAG_W-1:0] tau_xy_q, tau_yx_q;

  assign mxk    = s1_okk_q ? mot_k_q[2*MOT_W-1:MOT_W] : MOT_ZERO;
  assign myk    = s1_okk_q ? mot_k_q[MOT_W-1:0]       : MOT_ZERO;
  assign mxp    = s1_okp_q ? mot_p_q[2*MOT_W-1:MOT_W] : MOT_ZERO;
  assign myp    = s1_okp_q ? mot_p_q[MOT_W-1:0]       : MOT_ZERO;
  assign eq_xy  = (mxk == myp);
  assign eq_yx  = (myk == mxp);
  assign cxy_n  = cnt_xy_q + CNT_W'(eq_xy);
  assign cyx_n  = cnt_yx_q + CNT_W'(eq_yx);
  assign flat_n = flat_q || !(s1_nzok_q && nz_p_q[1] && nz_p_q[0]);
  assign fin_xy = flat_n ? '0 : cxy_n;
  assign fin_yx = flat_n ? '0 : cyx_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_xy_q  <= '0;
      cnt_yx_q  <= '0;
      flat_q    <= 1'b0;
      best_xy_q <= '0;
      best_yx_q <= '0;
      tau_xy_q  <= '0;
      tau_yx_q  <= '0;
    end else if (cmd_i.score_start) begin
      cnt_xy_q  <= '0;
      cnt_yx_q  <= '0;
      flat_q    <= 1'b0;
      best_xy_q <= '0;
      best_yx_q <= '0;
      tau_xy_q  <= '0;
      tau_yx_q  <= '0;
    end else if (s1_vld_q) begin
      if (s1_lag_end_q) begin
        cnt_xy_q <= '0;
        cnt_yx_q <= '0;
        flat_q   <= 1'b0;
        if (fin_xy > best_xy_q) begin
          best_xy_q <= fin_xy;
          tau_xy_q  <= s1_l_q;
        end
        if (fin_yx > best_yx_q) begin
          best_yx_q <= fin_yx;
          tau_yx_q  <= s1_l_q;
        end
      end else begin
        cnt_xy_q <= cxy_n;
        cnt_yx_q <= cyx_n;
        flat_q   <= flat_n;
      end
    end
  end

  // Decide edge, direction and weight
  logic             edge_d, x_wins;
  logic [LAG_W-1:0] win_tau;
  logic [DIR_W-1:0] dir_d;
  logic [WGT_W-1:0] wgt_d;

  always_comb begin
    edge_d  = (32'(best_xy_q) >= 32'(threshold_q)) || (32'(best_yx_q) >= 32'(threshold_q));
    x_wins  = (best_xy_q > best_yx_q) || ((best_xy_q == best_yx_q) && (tau_xy_q < tau_yx_q));
    win_tau = x_wins ? tau_xy_q : tau_yx_q;
    dir_d   = DIR_NONE;
    wgt_d   = '0;
    if (edge_d) begin
      if (win_tau == '0) begin
        dir_d = DIR_UNDIR;
        wgt_d = WGT_W'(1);
      end else begin
        dir_d = x_wins ? DIR_X_LEAD : DIR_Y_LEAD;
        wgt_d = WGT_W'(win_tau) + WGT_W'(1);
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.result_load) begin
      edge_res_o  <= edge_d;
      direction_o <= dir_d;
      weight_o    <= wgt_d;
      sync_xy_o   <= SYNC_W'(best_xy_q);
      sync_yx_o   <= SYNC_W'(best_yx_q);
      lag_xy_o    <= LAGO_W'(tau_xy_q);
      lag_yx_o    <= LAGO_W'(tau_yx_q);
    end
  end

endmodule

### hdl/msp_checker.sv
// Port-level checks for the motif sync pair block, bound to the top level.
module msp_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_valid_i,
  input logic                                   in_ready_o,
  input logic                                   last_i,
  input logic                                   out_valid_o,
  input logic                                   out_ready_i,
  input logic                                   edge_res_o,
  input logic [msp_pkg::DIR_W-1:0]              direction_o,
  input logic [msp_pkg::WGT_W-1:0]              weight_o,
  input logic [msp_pkg::SYNC_W-1:0]             sync_xy_o,
  input logic [msp_pkg::SYNC_W-1:0]             sync_yx_o,
  input logic [msp_pkg::LAGO_W-1:0]             lag_xy_o,
  input logic [msp_pkg::LAGO_W-1:0]             lag_yx_o
);
  import msp_pkg::*;

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(edge_res_o) &&
      $stable(direction_o) && $stable(weight_o) && $stable(sync_xy_o) &&
      $stable(sync_yx_o) && $stable(lag_xy_o) && $stable(lag_yx_o))
    else $error("result changed while stalled");

  // The closing transfer of a window blocks the input while scoring
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_i |=> !in_ready_o)
    else $error("input still open after last transfer");

  // A new result only follows a scoring pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result without scoring pass");

  // Edge flag agrees with direction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (edge_res_o == (direction_o != DIR_NONE)))
    else $error("edge flag and direction disagree");

  // Weight agrees with direction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((direction_o == DIR_NONE) == (weight_o == '0)) &&
      ((direction_o == DIR_UNDIR) == (weight_o == WGT_W'(1))))
    else $error("weight and direction disagree");

endmodule

bind motif_sync_pair msp_checker u_msp_checker (.*);

### bench/tb_motif_sync_pair.sv
// Self-checking testbench of the motif synchronization block for one channel pair.
module tb_motif_sync_pair;
  timeunit 1ns;
  timeprecision 1ps;

  import msp_pkg::*;

  // Bound on the scoring pass of one window at the widest lag range and window
  localparam int SCORE_CYCLES_MAX = (LAG_MAX + 1) * WINDOW_MAX + 3;
  localparam int CYCLE_LIMIT      = 6000000;
  localparam int RANDOM_ITEMS     = 950;

  typedef enum int {MIX_FREE, MIX_X_LEADS, MIX_Y_LEADS, MIX_NARROW, MIX_EXTREME} mix_e;

  typedef struct {
    logic              edge_res;
    logic [DIR_W-1:0]  direction;
    logic [WGT_W-1:0]  weight;
    logic [SYNC_W-1:0] sync_xy;
    logic [SYNC_W-1:0] sync_yx;
    logic [LAGO_W-1:0] lag_xy;
    logic [LAGO_W-1:0] lag_yx;
  } sync_verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_valid_i, cfg_ready_o;
  logic [CIDX_W-1:0] cfg_index_i;
  logic [CDAT_W-1:0] cfg_data_i;
  logic in_valid_i, in_ready_o;
  logic signed [SAMPLE_BITS-1:0] sample_x_i, sample_y_i;
  logic last_i;
  logic out_valid_o, out_ready_i;
  logic edge_res_o;
  logic [DIR_W-1:0] direction_o;
  logic [WGT_W-1:0] weight_o;
  logic [SYNC_W-1:0] sync_xy_o, sync_yx_o;
  logic [LAGO_W-1:0] lag_xy_o, lag_yx_o;

  motif_sync_pair dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .sample_x_i, .sample_y_i, .last_i,
    .out_valid_o, .out_ready_i,
    .edge_res_o, .direction_o, .weight_o, .sync_xy_o, .sync_yx_o, .lag_xy_o, .lag_yx_o
  );

  // Shadow copy of the registers and the sample store
  logic [WLEN_W-1:0] r_wlen;
  logic [LREG_W-1:0] r_lmin, r_lmax;
  logic [THR_W-1:0]  r_thr;
  logic [MOT_W-1:0]  mot_x [DEPTH];
  logic [MOT_W-1:0]  mot_y [DEPTH];
  bit                nz_x [DEPTH];
  bit                nz_y [DEPTH];
  logic signed [SAMPLE_BITS-1:0] prev_x [2];
  logic signed [SAMPLE_BITS-1:0] prev_y [2];
  int held;
  // Highest motif position count reached so far, to gate short windows
  int stored_mot;

  sync_verdict_t pending_verdicts[$];
  int failures     = 0;
  int items_sent   = 0;
  int cycle_count  = 0;
  bit quiet        = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Classify a run of three samples into a motif code
  function automatic logic [MOT_W-1:0] classify_run(
    input logic signed [SAMPLE_BITS-1:0] a,
    input logic signed [SAMPLE_BITS-1:0] b,
    input logic signed [SAMPLE_BITS-1:0] c
  );
    if (a > b && b > c) return MOT_FALL;
    if (a > b && b < c) return MOT_VALLEY;
    if (a < b && b > c) return MOT_PEAK;
    if (a < b && b < c) return MOT_RISE;
    if (a == 0 && b == 0 && c == 0) return MOT_ZERO;
    return MOT_OTHER;
  endfunction

  // Positions not received in this window read as motif zero and a zero sample
  function automatic logic [MOT_W-1:0] motif_at(bit of_y, int p);
    if (p < DEPTH && p + 2 < held) return of_y ? mot_y[p] : mot_x[p];
    return MOT_ZERO;
  endfunction

  function automatic bit nonzero_at(bit of_y, int p);
    if (p < DEPTH && p < held) return of_y ? nz_y[p] : nz_x[p];
    return 1'b0;
  endfunction

  // Score every lag of the closed window and decide the edge
  function automatic sync_verdict_t score_lags();
    sync_verdict_t v;
    int w, lmax, cxy, cyx, best_xy, best_yx, tau_xy, tau_yx, win;
    bit flat, x_wins;
    w = (r_wlen > WINDOW_MAX) ? WINDOW_MAX : int'(r_wlen);
    lmax = (r_lmax > LAG_MAX) ? LAG_MAX : int'(r_lmax);
    best_xy = 0; best_yx = 0; tau_xy = 0; tau_yx = 0;
    for (int l = int'(r_lmin); l <= lmax; l++) begin
      cxy = 0; cyx = 0; flat = 1'b0;
      for (int k = 0; k < w; k++) begin
        if (!nonzero_at(1'b0, k + l) || !nonzero_at(1'b1, k + l)) flat = 1'b1;
        if (motif_at(1'b0, k) == motif_at(1'b1, k + l)) cxy++;
        if (motif_at(1'b1, k) == motif_at(1'b0, k + l)) cyx++;
      end
      if (flat) begin
        cxy = 0; cyx = 0;
      end
      if (cxy > best_xy) begin
        best_xy = cxy; tau_xy = l;
      end
      if (cyx > best_yx) begin
        best_yx = cyx; tau_yx = l;
      end
    end
    v.edge_res  = (best_xy >= int'(r_thr)) || (best_yx >= int'(r_thr));
    v.direction = DIR_NONE;
    v.weight    = '0;
    if (v.edge_res) begin
      x_wins = (best_xy > best_yx) || (best_xy == best_yx && tau_xy < tau_yx);
      win = x_wins ? tau_xy : tau_yx;
      if (win == 0) begin
        v.direction = DIR_UNDIR;
        v.weight    = WGT_W'(1);
      end else begin
        v.direction = x_wins ? DIR_X_LEAD : DIR_Y_LEAD;
        v.weight    = WGT_W'(win + 1);
      end
    end
    v.sync_xy = SYNC_W'(best_xy);
    v.sync_yx = SYNC_W'(best_yx);
    v.lag_xy  = LAGO_W'(tau_xy);
    v.lag_yx  = LAGO_W'(tau_yx);
    return v;
  endfunction

  // Advance the shadow store by one accepted pair
  task automatic track_pair(input logic signed [SAMPLE_BITS-1:0] x, y, input logic closes);
    int n;
    n = held;
    if (n < DEPTH) begin
      nz_x[n] = (x != 0);
      nz_y[n] = (y != 0);
      if (n >= 2) begin
        mot_x[n-2] = classify_run(prev_x[1], prev_x[0], x);
        mot_y[n-2] = classify_run(prev_y[1], prev_y[0], y);
        if (n - 1 > stored_mot) stored_mot = n - 1;
      end
      held = n + 1;
    end
    prev_x[1] = prev_x[0]; prev_x[0] = x;
    prev_y[1] = prev_y[0]; prev_y[0] = y;
    if (closes) begin
      pending_verdicts.push_back(score_lags());
      held = 0;
      prev_x[0] = '0; prev_x[1] = '0;
      prev_y[0] = '0; prev_y[1] = '0;
    end
  endtask

  // Send one sample pair, with a random gap ahead of it
  task automatic send_pair(input logic signed [SAMPLE_BITS-1:0] x, y, input logic closes);
    @(negedge clk_i);
    while (!quiet && $urandom_range(99) < 9) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_x_i <= x;
    sample_y_i <= y;
    last_i     <= closes;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    track_pair(x, y, closes);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_WINDOW_LEN: r_wlen = data;
      CFG_LAG_MIN:    r_lmin = data[LREG_W-1:0];
      CFG_LAG_MAX:    r_lmax = data[LREG_W-1:0];
      CFG_THRESHOLD:  r_thr  = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic apply_settings(input logic [CDAT_W-1:0] wl, lmn, lmx, thr);
    write_reg(CFG_WINDOW_LEN, wl);
    write_reg(CFG_LAG_MIN, lmn);
    write_reg(CFG_LAG_MAX, lmx);
    write_reg(CFG_THRESHOLD, thr);
  endtask

  // Drop the input, drain the results and let a full scoring pass go by
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (SCORE_CYCLES_MAX) @(posedge clk_i);
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] draw_sample(mix_e mix);
    logic [31:0] r;
    r = $urandom();
    case (mix)
      MIX_NARROW: return SAMPLE_BITS'(int'($urandom_range(4)) - 2);
      MIX_EXTREME: begin
        case (r[2:0])
          3'd0:    return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
          3'd1:    return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
          3'd2:    return '0;
          3'd3:    return '1;
          3'd4:    return SAMPLE_BITS'(1);
          default: return r[31:32-SAMPLE_BITS];
        endcase
      end
      default: begin
        if (r[31:27] == '0) return '0;
        return r[SAMPLE_BITS-1:0];
      end
    endcase
  endfunction

  // Send one window; in the leading mixes one channel is a delayed copy of the other
  task automatic send_window(input int len, input mix_e mix, input int shift);
    logic signed [SAMPLE_BITS-1:0] xs[$];
    logic signed [SAMPLE_BITS-1:0] ys[$];
    logic signed [SAMPLE_BITS-1:0] a, b;
    for (int n = 0; n < len; n++) begin
      a = draw_sample(mix);
      b = draw_sample(mix);
      if (mix == MIX_X_LEADS && n >= shift) b = xs[n-shift];
      if (mix == MIX_Y_LEADS && n >= shift) a = ys[n-shift];
      xs.push_back(a);
      ys.push_back(b);
      send_pair(a, b, n == len - 1);
    end
  endtask

  // Full-scale extremes and every motif class but zero, with an edge always reported
  task automatic test_motif_classes();
    apply_settings(7'd3, 7'd0, 7'd1, 7'd0);
    send_pair(32767, -32768, 1'b0);
    send_pair(-32768, -100, 1'b0);
    send_pair(32767, 5, 1'b0);
    send_pair(100, 50, 1'b0);
    send_pair(-5, 50, 1'b0);
    send_pair(-5, 50, 1'b1);
    settle();
  endtask

  // All-zero runs, then a window shorter than the compare span
  task automatic test_flat_and_short();
    apply_settings(7'd3, 7'd0, 7'd1, THRESHOLD_RST);
    send_pair(0, 0, 1'b0);
    send_pair(0, 0, 1'b0);
    send_pair(0, 0, 1'b0);
    send_pair(0, 3, 1'b0);
    send_pair(9, 3, 1'b1);
    send_pair(-1, 7, 1'b0);
    send_pair(4, -2, 1'b0);
    send_pair(-6, 11, 1'b1);
    settle();
  endtask

  // No lag to try, then no position to compare
  task automatic test_empty_scoring();
    apply_settings(7'd3, 7'd3, 7'd1, 7'd1);
    send_pair(5, -5, 1'b1);
    settle();
    apply_settings(7'd0, 7'd0, 7'd1, 7'd1);
    send_pair(-7, 8, 1'b1);
    settle();
  endtask

  // y repeats x two samples later, so x leads at lag two
  task automatic test_lagged_copy();
    apply_settings(7'd4, 7'd0, 7'd2, 7'd2);
    send_pair(10, 4, 1'b0);
    send_pair(-20, -6, 1'b0);
    send_pair(30, 10, 1'b0);
    send_pair(5, -20, 1'b0);
    send_pair(7, 30, 1'b0);
    send_pair(-3, 5, 1'b0);
    send_pair(12, 7, 1'b0);
    send_pair(1, -3, 1'b1);
    settle();
  endtask

  // Random settings per phase, mostly well-formed windows with correlated channels
  task automatic test_random_windows();
    int start, phase, phase_items, full, len, w_eff, l_eff, r, shift;
    logic [CDAT_W-1:0] wl, lmn, lmx, thr;
    mix_e mix;
    start = items_sent;
    phase = 0;
    while (items_sent - start < RANDOM_ITEMS) begin
      quiet = (phase == 1);
      if (phase == 0) begin
        apply_settings(CDAT_W'(WINDOW_LEN_RST), CDAT_W'(LAG_MIN_RST),
                       CDAT_W'(LAG_MAX_RST), CDAT_W'(THRESHOLD_RST));
      end else begin
        r = $urandom_range(9);
        wl = (r == 0) ? 7'd0 : (r == 1) ? 7'd127 : (r == 2) ? 7'd64 : 7'($urandom_range(1, 48));
        lmx = ($urandom_range(9) == 0) ? 7'($urandom_range(17, 31)) : 7'($urandom_range(0, 16));
        if ($urandom_range(9) == 0) lmn = 7'($urandom_range(0, 31));
        else lmn = 7'($urandom_range(0, (lmx > 16) ? 16 : int'(lmx)));
        // Upper data bits are dropped by the five-bit lag registers
        if ($urandom_range(5) == 0) lmn[6:5] = 2'($urandom_range(1, 3));
        if ($urandom_range(5) == 0) lmx[6:5] = 2'($urandom_range(1, 3));
        w_eff = (wl > WINDOW_MAX) ? WINDOW_MAX : int'(wl);
        r = $urandom_range(19);
        thr = (r == 0) ? 7'd0 : (r == 1) ? 7'd127 : 7'($urandom_range(w_eff / 4, w_eff + 2));
        apply_settings(wl, lmn, lmx, thr);
      end
      w_eff = (r_wlen > WINDOW_MAX) ? WINDOW_MAX : int'(r_wlen);
      l_eff = (r_lmax > LAG_MAX) ? LAG_MAX : int'(r_lmax);
      full = w_eff + l_eff + 2;
      phase_items = 0;
      while (phase_items < 120) begin
        r = $urandom_range(9);
        if (r == 0 && w_eff + l_eff <= stored_mot) len = $urandom_range(1, full - 1);
        else if (r == 1) len = full + $urandom_range(1, 6);
        else if (r == 2 && $urandom_range(3) == 0) len = DEPTH + $urandom_range(1, 6);
        else len = full;
        r = $urandom_range(99);
        mix = (r < 30) ? MIX_X_LEADS : (r < 60) ? MIX_Y_LEADS :
              (r < 75) ? MIX_FREE : (r < 90) ? MIX_NARROW : MIX_EXTREME;
        shift = $urandom_range(0, l_eff);
        send_window(len, mix, shift);
        phase_items += len;
      end
      settle();
      phase++;
    end
    quiet = 1'b0;
  endtask

  function automatic void match_field(input string name, input logic [31:0] want, got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  // Compare each result transfer with the oldest pending verdict
  always @(posedge clk_i) begin : check_results
    sync_verdict_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_verdicts.size() == 0) begin
        $error("result transfer with no pending verdict");
        failures++;
      end else begin
        want = pending_verdicts.pop_front();
        match_field("edge_res", 32'(want.edge_res), 32'(edge_res_o));
        match_field("direction", 32'(want.direction), 32'(direction_o));
        match_field("weight", 32'(want.weight), 32'(weight_o));
        match_field("sync_xy", 32'(want.sync_xy), 32'(sync_xy_o));
        match_field("sync_yx", 32'(want.sync_yx), 32'(sync_yx_o));
        match_field("lag_xy", 32'(want.lag_xy), 32'(lag_xy_o));
        match_field("lag_yx", 32'(want.lag_yx), 32'(lag_yx_o));
      end
    end
  end

  // Stall the result side at random
  always @(negedge clk_i) begin
    out_ready_i <= quiet ? 1'b1 : ($urandom_range(99) >= 9);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    sample_x_i  = '0;
    sample_y_i  = '0;
    last_i      = 1'b0;
    out_ready_i = 1'b0;
    r_wlen = WINDOW_LEN_RST;
    r_lmin = LAG_MIN_RST;
    r_lmax = LAG_MAX_RST;
    r_thr  = THRESHOLD_RST;
    for (int i = 0; i < DEPTH; i++) begin
      mot_x[i] = MOT_ZERO; mot_y[i] = MOT_ZERO;
      nz_x[i] = 1'b0; nz_y[i] = 1'b0;
    end
    prev_x[0] = '0; prev_x[1] = '0;
    prev_y[0] = '0; prev_y[1] = '0;
    held = 0;
    stored_mot = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_motif_classes();
    test_flat_and_short();
    test_empty_scoring();
    test_lagged_copy();
    test_random_windows();

    settle();
    if (pending_verdicts.size() != 0) failures++;
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
